// ===== rtl/jbt_pkg.sv =====
// ============================================================================
// jbt_pkg
// Shared types, codes and character helpers for the JSON byte tokenizer.
// ============================================================================
package jbt_pkg;

    // Default cap on characters emitted in one string
    localparam int STRING_CAP_DEF = 4095;

    // Token kind codes
    localparam logic [3:0] K_END      = 4'd0;
    localparam logic [3:0] K_LBRACE   = 4'd1;
    localparam logic [3:0] K_RBRACE   = 4'd2;
    localparam logic [3:0] K_LBRACKET = 4'd3;
    localparam logic [3:0] K_RBRACKET = 4'd4;
    localparam logic [3:0] K_COLON    = 4'd5;
    localparam logic [3:0] K_COMMA    = 4'd6;
    localparam logic [3:0] K_STRCLOSE = 4'd7;
    localparam logic [3:0] K_NUMBER   = 4'd8;
    localparam logic [3:0] K_TRUE     = 4'd9;
    localparam logic [3:0] K_FALSE    = 4'd10;
    localparam logic [3:0] K_NULL     = 4'd11;
    localparam logic [3:0] K_ERROR    = 4'd12;
    localparam logic [3:0] K_CHAR     = 4'd13;

    // Lexer mode codes
    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_STR  = 3'd1;
    localparam logic [2:0] M_ESC  = 3'd2;
    localparam logic [2:0] M_NUM  = 3'd3;
    localparam logic [2:0] M_FRAC = 3'd4;
    localparam logic [2:0] M_WORD = 3'd5;

    // Character codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Word length saturates here
    localparam logic [2:0] WORD_LEN_MAX = 3'd6;

    // Keyword candidate bits
    localparam int CAND_TRUE  = 0;
    localparam int CAND_FALSE = 1;
    localparam int CAND_NULL  = 2;

    // One token in the result queue
    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  chv;
        logic [63:0] num;
        logic        last;
    } token_t;

    function automatic logic is_digit(logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_letter(logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    // Backslash escape decode; unknown escapes pass through
    function automatic logic [7:0] esc_map(logic [7:0] b);
        logic [7:0] c;
        case (b)
            8'h6E:   c = CH_LF;
            8'h74:   c = CH_TAB;
            8'h72:   c = CH_CR;
            8'h62:   c = CH_BS;
            8'h66:   c = CH_FF;
            default: c = b;
        endcase
        return c;
    endfunction

    // Keep only the keywords whose letter at position len equals b
    function automatic logic [2:0] word_cand_next(logic [2:0] cand, logic [2:0] len,
                                                  logic [7:0] b);
        logic [7:0] ct;
        logic [7:0] cf;
        logic [7:0] cn;
        logic [2:0] ok;
        ct = 8'h00;
        cf = 8'h00;
        cn = 8'h00;
        ok = 3'b000;
        case (len)
            3'd0:
            begin
                ct = 8'h74; cf = 8'h66; cn = 8'h6E;
                ok = 3'b111;
            end
            3'd1:
            begin
                ct = 8'h72; cf = 8'h61; cn = 8'h75;
                ok = 3'b111;
            end
            3'd2:
            begin
                ct = 8'h75; cf = 8'h6C; cn = 8'h6C;
                ok = 3'b111;
            end
            3'd3:
            begin
                ct = 8'h65; cf = 8'h73; cn = 8'h6C;
                ok = 3'b111;
            end
            3'd4:
            begin
                cf = 8'h65;
                ok = 3'b010;
            end
            default:
            begin
                ok = 3'b000;
            end
        endcase
        ok[CAND_TRUE]  = ok[CAND_TRUE]  && (b == ct);
        ok[CAND_FALSE] = ok[CAND_FALSE] && (b == cf);
        ok[CAND_NULL]  = ok[CAND_NULL]  && (b == cn);
        return cand & ok;
    endfunction

    // Token kind for a finished letter run
    function automatic logic [3:0] word_kind(logic [2:0] cand, logic [2:0] len);
        logic [3:0] k;
        if (cand[CAND_TRUE] && len == 3'd4)
        begin
            k = K_TRUE;
        end
        else if (cand[CAND_FALSE] && len == 3'd5)
        begin
            k = K_FALSE;
        end
        else if (cand[CAND_NULL] && len == 3'd4)
        begin
            k = K_NULL;
        end
        else
        begin
            k = K_ERROR;
        end
        return k;
    endfunction

endpackage

// ===== rtl/jbt_if.sv =====
// ============================================================================
// jbt_if
// Valid/ready channels: input bytes and output tokens.
// ============================================================================
interface jbt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       at_end;

    modport source (output valid, output in_byte, output at_end, input ready);
    modport sink   (input valid, input in_byte, input at_end, output ready);
endinterface

interface jbt_token_if;
    logic               valid;
    logic               ready;
    logic [3:0]         out_kind;
    logic [7:0]         char_value;
    logic signed [63:0] number_value;
    logic               out_last;

    modport source (output valid, output out_kind, output char_value,
                    output number_value, output out_last, input ready);
    modport sink   (input valid, input out_kind, input char_value,
                    input number_value, input out_last, output ready);
endinterface

// ===== rtl/json_byte_tokenizer.sv =====
// ============================================================================
// json_byte_tokenizer
// Streaming JSON lexer: one byte (or end mark) in, zero to two tokens out.
// ============================================================================
// Takes one byte request per clock when the token queue has room and emits
// JSON tokens on the output channel, one token per cycle while the consumer
// is ready. A byte is held in an input register, decoded combinationally
// against the lexer state (mode, 64-bit integer accumulator, string length,
// keyword match bits) and its tokens are written into a four-entry token
// queue whose head drives the output; a full queue holds the byte in the
// input register. Input throughput is one byte per cycle while the consumer
// keeps up; bytes that produce two tokens (number or word terminators,
// string length cap, end mark) are then limited by the single output port,
// which drains one token a cycle.
// out_last marks the final token produced by each request.
module json_byte_tokenizer #(
    parameter int STRING_CAP = jbt_pkg::STRING_CAP_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    jbt_byte_if.sink     byte_chan,
    jbt_token_if.source  token_chan
);
    import jbt_pkg::*;

    localparam int SW         = $clog2(STRING_CAP + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int PW         = $clog2(FIFO_DEPTH);
    localparam int CW         = $clog2(FIFO_DEPTH + 1);

    // Input register
    logic       in_v_reg;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;

    // Lexer state
    logic [2:0]    mode_reg,  mode_next;
    logic [63:0]   acc_reg,   acc_next;
    logic          minus_reg, minus_next;
    logic [SW-1:0] slen_reg,  slen_next;
    logic [2:0]    wlen_reg,  wlen_next;
    logic [2:0]    cand_reg,  cand_next;

    // Token queue
    token_t        fifo_reg [FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] cnt_reg;

    logic consume;
    logic in_take;
    logic pop;

    // Decode results
    logic          lead_v, tail_v;
    logic [3:0]    lead_kind, tail_kind;
    logic [7:0]    lead_chv;
    logic [63:0]   lead_num;
    logic          do_char, run_idle;
    logic [7:0]    char_in;
    logic [SW:0]   slen_inc;
    logic [63:0]   num_res;
    logic [63:0]   acc_x10;
    logic [63:0]   digit64;
    logic [7:0]    b;
    token_t        ent0, ent1;
    logic [1:0]    push_n;

    // Handshake
    assign consume         = in_v_reg && (cnt_reg <= CW'(FIFO_DEPTH - 2));
    assign byte_chan.ready = !in_v_reg || consume;
    assign in_take         = byte_chan.valid && byte_chan.ready;
    assign pop             = (cnt_reg != '0) && token_chan.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (byte_chan.ready)
        begin
            in_v_reg <= byte_chan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= byte_chan.in_byte;
            in_end_reg  <= byte_chan.at_end;
        end
    end

    // Datapath helpers
    assign b        = in_byte_reg;
    assign num_res  = minus_reg ? (64'd0 - acc_reg) : acc_reg;
    assign digit64  = {60'd0, b[3:0]};
    assign acc_x10  = {acc_reg[60:0], 3'b000} + {acc_reg[62:0], 1'b0} + digit64;
    assign slen_inc = {1'b0, slen_reg} + {{SW{1'b0}}, 1'b1};

    // Byte decode and next state
    always_comb
    begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        minus_next = minus_reg;
        slen_next  = slen_reg;
        wlen_next  = wlen_reg;
        cand_next  = cand_reg;
        lead_v     = 1'b0;
        lead_kind  = K_END;
        lead_chv   = 8'd0;
        lead_num   = 64'd0;
        tail_v     = 1'b0;
        tail_kind  = K_END;
        do_char    = 1'b0;
        run_idle   = 1'b0;
        char_in    = b;

        if (in_end_reg)
        begin
            // Flush pending token, then end
            case (mode_reg)
                M_STR, M_ESC:
                begin
                    lead_v    = 1'b1;
                    lead_kind = K_STRCLOSE;
                end
                M_NUM, M_FRAC:
                begin
                    lead_v    = 1'b1;
                    lead_kind = K_NUMBER;
                    lead_num  = num_res;
                end
                M_WORD:
                begin
                    lead_v    = 1'b1;
                    lead_kind = word_kind(cand_reg, wlen_reg);
                end
                default:
                begin
                    lead_v = 1'b0;
                end
            endcase
            tail_v     = 1'b1;
            tail_kind  = K_END;
            mode_next  = M_IDLE;
            acc_next   = 64'd0;
            minus_next = 1'b0;
            slen_next  = '0;
            wlen_next  = 3'd0;
            cand_next  = 3'b111;
        end
        else
        begin
            case (mode_reg)
                M_STR:
                begin
                    if (b == CH_QUOTE)
                    begin
                        lead_v    = 1'b1;
                        lead_kind = K_STRCLOSE;
                        mode_next = M_IDLE;
                    end
                    else if (b == CH_BSLASH)
                    begin
                        mode_next = M_ESC;
                    end
                    else
                    begin
                        do_char = 1'b1;
                    end
                end
                M_ESC:
                begin
                    mode_next = M_STR;
                    do_char   = 1'b1;
                    char_in   = esc_map(b);
                end
                M_NUM:
                begin
                    if (is_digit(b))
                    begin
                        acc_next = acc_x10;
                    end
                    else if (b == CH_DOT)
                    begin
                        mode_next = M_FRAC;
                    end
                    else
                    begin
                        lead_v    = 1'b1;
                        lead_kind = K_NUMBER;
                        lead_num  = num_res;
                        run_idle  = 1'b1;
                    end
                end
                M_FRAC:
                begin
                    if (!is_digit(b))
                    begin
                        lead_v    = 1'b1;
                        lead_kind = K_NUMBER;
                        lead_num  = num_res;
                        run_idle  = 1'b1;
                    end
                end
                M_WORD:
                begin
                    if (is_letter(b))
                    begin
                        cand_next = word_cand_next(cand_reg, wlen_reg, b);
                        wlen_next = (wlen_reg < WORD_LEN_MAX) ? wlen_reg + 3'd1 : wlen_reg;
                    end
                    else
                    begin
                        lead_v    = 1'b1;
                        lead_kind = word_kind(cand_reg, wlen_reg);
                        run_idle  = 1'b1;
                    end
                end
                default:
                begin
                    run_idle = 1'b1;
                end
            endcase

            // String character, closing the string at the length cap
            if (do_char)
            begin
                lead_v    = 1'b1;
                lead_kind = K_CHAR;
                lead_chv  = char_in;
                slen_next = slen_inc[SW-1:0];
                if (slen_inc >= (SW + 1)'(STRING_CAP))
                begin
                    tail_v    = 1'b1;
                    tail_kind = K_STRCLOSE;
                    mode_next = M_IDLE;
                end
            end

            // Byte seen from idle (also the terminator of a number or word)
            if (run_idle)
            begin
                mode_next = M_IDLE;
                case (b)
                    CH_SPACE, CH_TAB, CH_LF, CH_CR:
                    begin
                        tail_v = 1'b0;
                    end
                    8'h7B:
                    begin
                        tail_v = 1'b1; tail_kind = K_LBRACE;
                    end
                    8'h7D:
                    begin
                        tail_v = 1'b1; tail_kind = K_RBRACE;
                    end
                    8'h5B:
                    begin
                        tail_v = 1'b1; tail_kind = K_LBRACKET;
                    end
                    8'h5D:
                    begin
                        tail_v = 1'b1; tail_kind = K_RBRACKET;
                    end
                    8'h3A:
                    begin
                        tail_v = 1'b1; tail_kind = K_COLON;
                    end
                    8'h2C:
                    begin
                        tail_v = 1'b1; tail_kind = K_COMMA;
                    end
                    CH_QUOTE:
                    begin
                        mode_next = M_STR;
                        slen_next = '0;
                    end
                    CH_MINUS:
                    begin
                        mode_next  = M_NUM;
                        minus_next = 1'b1;
                        acc_next   = 64'd0;
                    end
                    default:
                    begin
                        if (is_digit(b))
                        begin
                            mode_next  = M_NUM;
                            minus_next = 1'b0;
                            acc_next   = digit64;
                        end
                        else if (is_letter(b))
                        begin
                            mode_next = M_WORD;
                            wlen_next = 3'd1;
                            cand_next = word_cand_next(3'b111, 3'd0, b);
                        end
                        else
                        begin
                            tail_v    = 1'b1;
                            tail_kind = K_ERROR;
                        end
                    end
                endcase
            end
        end
    end

    // Pack up to two tokens in order, last flag on the final one
    always_comb
    begin
        ent0 = '{kind: lead_kind, chv: lead_chv, num: lead_num, last: !tail_v};
        ent1 = '{kind: tail_kind, chv: 8'd0, num: 64'd0, last: 1'b1};
        if (!lead_v)
        begin
            ent0 = ent1;
        end
        push_n = consume ? ({1'b0, lead_v} + {1'b0, tail_v}) : 2'd0;
    end

    // Lexer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            acc_reg   <= 64'd0;
            minus_reg <= 1'b0;
            slen_reg  <= '0;
            wlen_reg  <= 3'd0;
            cand_reg  <= 3'b111;
        end
        else if (consume)
        begin
            mode_reg  <= mode_next;
            acc_reg   <= acc_next;
            minus_reg <= minus_next;
            slen_reg  <= slen_next;
            wlen_reg  <= wlen_next;
            cand_reg  <= cand_next;
        end
    end

    // Token queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PW'(push_n);
            rd_ptr_reg <= rd_ptr_reg + PW'(pop);
            cnt_reg    <= cnt_reg + CW'(push_n) - CW'(pop);
        end
    end

    // Token queue storage
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= ent0;
        end
        if (push_n == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + PW'(1)] <= ent1;
        end
    end

    // Output from queue head
    assign token_chan.valid        = (cnt_reg != '0);
    assign token_chan.out_kind     = fifo_reg[rd_ptr_reg].kind;
    assign token_chan.char_value   = fifo_reg[rd_ptr_reg].chv;
    assign token_chan.number_value = fifo_reg[rd_ptr_reg].num;
    assign token_chan.out_last     = fifo_reg[rd_ptr_reg].last;

    // Checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(FIFO_DEPTH))
        else $error("token queue overflow");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != 2'd0) |-> (cnt_reg <= CW'(FIFO_DEPTH - 2)))
        else $error("token written without room");

    a_slen_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == M_STR || mode_reg == M_ESC) |-> (slen_reg < SW'(STRING_CAP)))
        else $error("string length beyond cap while in string");

    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && in_end_reg) |=> (mode_reg == M_IDLE && acc_reg == 64'd0))
        else $error("state not cleared after end mark");

endmodule
